// File: design/cell_balance_discharge_scheduler_defines.svh
// Assertion helpers for the discharge scheduler.
`ifndef CELL_BALANCE_DISCHARGE_SCHEDULER_DEFINES_SVH
`define CELL_BALANCE_DISCHARGE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CBDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CBDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cbds_pkg.sv
package cbds_pkg;

  // request opcodes
  localparam logic [1:0] OP_MODE = 2'd0;
  localparam logic [1:0] OP_VOLT = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // poll status codes
  localparam logic [1:0] PS_LIMIT = 2'd1;
  localparam logic [1:0] PS_DISC  = 2'd2;

  // limit event codes
  localparam logic [1:0] LE_NONE  = 2'd0;
  localparam logic [1:0] LE_LIMIT = 2'd1;
  localparam logic [1:0] LE_OK    = 2'd2;

  localparam logic [4:0] FRAME_TICKS = 5'd16;
  localparam logic [7:0] FAULT_LIMIT_RST = 8'd10;
  localparam logic [1:0] LAST_STEP = 2'd3;

  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_SURV    = 2'd1,
    MODE_STANDBY = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_LOAD,
    ST_FIRST,
    ST_STEP,
    ST_TICK
  } state_t;

  // shared subtract unit operations
  typedef enum logic [2:0] {
    DU_IDLE,
    DU_WIN,
    DU_LOAD,
    DU_FIRST,
    DU_STEP
  } du_op_t;

  typedef struct packed {
    logic borrow;
    logic zero;
  } du_flags_t;

  typedef struct packed {
    logic volt_we;
    logic cnt_we;
    logic clear_all;
    logic tick;
  } bank_ctl_t;

endpackage

// File: design/cell_balance_discharge_scheduler.sv
// A request that is not an active tick gives its result in the cycle after acceptance.
// An active tick inside a frame passes through the tick state alone; at a frame start the
// shared subtractor runs a window step, then per cell a load, a compare and up to four
// quotient steps, then the tick state. busy is high until the tick state has passed.
// Reset (rst, synchronous): surveillance mode, voltages and counts zero, fault_limit 10.
// Results are strobed by done for one cycle; the receiver cannot stall.
module cell_balance_discharge_scheduler #(
  parameter int CELLS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [1:0]  mode,
  input  logic [3:0]  cell_req,
  input  logic [11:0] voltage,
  input  logic [11:0] win_low,
  input  logic [11:0] win_high,
  input  logic [1:0]  poll_status,
  output logic        done,
  output logic [11:0] load_mask,
  output logic        load_update,
  output logic        led_on,
  output logic [1:0]  limit_event,
  output logic        cable_break,
  output logic        standby_request,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbds_pkg::*;
  `include "cell_balance_discharge_scheduler_defines.svh"

  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);

  state_t      state, state_next;
  mode_t       run_mode, run_mode_next;
  logic [4:0]  frame_count, frame_count_next;
  logic [7:0]  disconnect_count, disconnect_count_next;
  logic        led_level, led_level_next;
  logic [7:0]  fault_limit;
  logic [IDX_W-1:0] idx;
  logic [1:0]  step;
  logic [11:0] lo, hi;
  logic [1:0]  status;

  logic        accept;
  logic        last_cell;
  logic        cell_done;
  logic        done_next;
  logic [11:0] mask_next;
  logic        update_next;
  logic [1:0]  event_next;
  logic        cable_next;
  logic        standby_next;

  du_op_t      du_op;
  du_flags_t   flags;
  logic [4:0]  quo_next;
  bank_ctl_t   bank_ctl;
  logic [11:0] rd_volt;
  logic [CELLS-1:0] bank_mask;
  logic [15:0] mask_wide;
  logic        volt_in_range;

  // poll evaluation
  logic [1:0]  poll_src;
  logic [1:0]  poll_event;
  logic        poll_cable;
  logic [7:0]  poll_count;

  assign accept = start && (state == ST_IDLE);
  assign busy = (state != ST_IDLE);
  assign last_cell = (idx == LAST_CELL);
  assign volt_in_range = ({1'b0, cell_req} < 5'(CELLS));
  assign mask_wide = 16'(bank_mask);

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, fault_limit};

  cbds_divider u_div (
    .clk      (clk),
    .du_op    (du_op),
    .volt     (rd_volt),
    .lo       (lo),
    .hi       (hi),
    .flags    (flags),
    .quo_next (quo_next)
  );

  cbds_cell_bank #(
    .CELLS (CELLS),
    .IDX_W (IDX_W)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (bank_ctl),
    .volt_idx  (cell_req[IDX_W-1:0]),
    .volt_data (voltage),
    .rd_idx    (idx),
    .rd_volt   (rd_volt),
    .cnt_idx   (idx),
    .cnt_data  (quo_next),
    .mask      (bank_mask)
  );

  // cell finished in the recalculation walk
  always_comb begin
    cell_done = 1'b0;
    unique case (state)
      ST_LOAD:  cell_done = flags.borrow;
      ST_FIRST: cell_done = !flags.borrow;
      ST_STEP:  cell_done = (step == LAST_STEP);
      default:  cell_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_TICK && run_mode == MODE_ACTIVE) begin
          state_next = (frame_count == 5'd0) ? ST_WIN : ST_TICK;
        end
      end
      ST_WIN: begin
        state_next = (flags.zero || flags.borrow) ? ST_TICK : ST_LOAD;
      end
      ST_LOAD: begin
        if (!flags.borrow) begin
          state_next = ST_FIRST;
        end else if (last_cell) begin
          state_next = ST_TICK;
        end
      end
      ST_FIRST: begin
        if (flags.borrow) begin
          state_next = ST_STEP;
        end else begin
          state_next = last_cell ? ST_TICK : ST_LOAD;
        end
      end
      ST_STEP: begin
        if (step == LAST_STEP) begin
          state_next = last_cell ? ST_TICK : ST_LOAD;
        end
      end
      ST_TICK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    du_op = DU_IDLE;
    bank_ctl = '0;
    unique case (state)
      ST_WIN: begin
        du_op = DU_WIN;
        bank_ctl.clear_all = flags.zero;
      end
      ST_LOAD: begin
        du_op = DU_LOAD;
      end
      ST_FIRST: begin
        du_op = DU_FIRST;
        bank_ctl.cnt_we = flags.zero;
      end
      ST_STEP: begin
        du_op = DU_STEP;
        bank_ctl.cnt_we = (step == LAST_STEP);
      end
      ST_TICK: begin
        bank_ctl.tick = 1'b1;
      end
      default: begin
      end
    endcase
    bank_ctl.volt_we = accept && (op == OP_VOLT) && volt_in_range;
  end

  // poll status evaluation
  always_comb begin
    poll_src = (state == ST_TICK) ? status : poll_status;
    poll_event = LE_NONE;
    poll_cable = 1'b0;
    poll_count = disconnect_count;
    if (poll_src == PS_LIMIT) begin
      poll_event = LE_LIMIT;
    end else if (poll_src == PS_DISC) begin
      if (disconnect_count != 8'hFF) begin
        poll_count = disconnect_count + 8'd1;
      end
      poll_cable = (poll_count > fault_limit);
    end else begin
      poll_count = 8'd0;
      poll_event = LE_OK;
    end
  end

  // result and mode state update
  always_comb begin
    done_next = 1'b0;
    mask_next = 12'd0;
    update_next = 1'b0;
    event_next = LE_NONE;
    cable_next = 1'b0;
    standby_next = 1'b0;
    run_mode_next = run_mode;
    frame_count_next = frame_count;
    disconnect_count_next = disconnect_count;
    led_level_next = led_level;
    if (accept) begin
      unique case (op)
        OP_MODE: begin
          run_mode_next = mode_t'(mode);
          done_next = 1'b1;
        end
        OP_TICK: begin
          unique case (run_mode)
            MODE_ACTIVE: begin
            end
            MODE_SURV: begin
              done_next = 1'b1;
              if (frame_count != 5'd0) begin
                frame_count_next = 5'd0;
                led_level_next = 1'b0;
                update_next = 1'b1;
              end
              event_next = poll_event;
              cable_next = poll_cable;
              disconnect_count_next = poll_count;
            end
            MODE_STANDBY: begin
              done_next = 1'b1;
              standby_next = 1'b1;
              run_mode_next = MODE_OFF;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
    end else if (state == ST_TICK) begin
      done_next = 1'b1;
      mask_next = mask_wide[11:0];
      update_next = 1'b1;
      led_level_next = ~led_level;
      frame_count_next = (frame_count == 5'd0) ? (FRAME_TICKS - 5'd1)
                                               : (frame_count - 5'd1);
      event_next = poll_event;
      cable_next = poll_cable;
      disconnect_count_next = poll_count;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run_mode <= MODE_SURV;
      frame_count <= 5'd0;
      disconnect_count <= 8'd0;
      led_level <= 1'b0;
      fault_limit <= FAULT_LIMIT_RST;
      done <= 1'b0;
      idx <= '0;
      step <= 2'd0;
    end else begin
      state <= state_next;
      run_mode <= run_mode_next;
      frame_count <= frame_count_next;
      disconnect_count <= disconnect_count_next;
      led_level <= led_level_next;
      done <= done_next;
      if (psel && penable && pwrite && !paddr[2]) begin
        fault_limit <= pwdata[7:0];
      end
      if (state == ST_WIN) begin
        idx <= '0;
      end else if (cell_done && !last_cell) begin
        idx <= idx + IDX_W'(1);
      end
      if (state == ST_FIRST) begin
        step <= 2'd0;
      end else if (state == ST_STEP) begin
        step <= step + 2'd1;
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lo <= win_low;
      hi <= win_high;
      status <= poll_status;
    end
    load_mask <= mask_next;
    load_update <= update_next;
    led_on <= led_level_next;
    limit_event <= event_next;
    cable_break <= cable_next;
    standby_request <= standby_next;
  end

  `CBDS_ASSERT_NXT(a_quick_result, accept && (op != OP_TICK || run_mode != MODE_ACTIVE), done, "non-active request must finish in one cycle")
  `CBDS_ASSERT_NXT(a_tick_result, state == ST_TICK, done && load_update && !busy, "active tick must write the load mask")
  `CBDS_ASSERT_IMP(a_done_idle, done, !busy, "result strobed while busy")
  `CBDS_ASSERT_IMP(a_standby_alone, standby_request, done && !load_update && limit_event == LE_NONE, "standby result carries actions")

endmodule

// File: design/cbds_divider.sv
// Shared subtractor with remainder, quotient and window registers.
// Computes floor(16*x/d) one quotient bit per step.
module cbds_divider (
  input  logic              clk,
  input  cbds_pkg::du_op_t  du_op,
  input  logic [11:0]       volt,
  input  logic [11:0]       lo,
  input  logic [11:0]       hi,
  output cbds_pkg::du_flags_t flags,
  output logic [4:0]        quo_next
);
  import cbds_pkg::*;

  logic [11:0] rem;
  logic [11:0] den;
  logic [4:0]  quo;
  logic [12:0] op_a;
  logic [12:0] op_b;
  logic [13:0] diff;

  // operand select
  always_comb begin
    op_a = {1'b0, rem};
    op_b = {1'b0, den};
    unique case (du_op)
      DU_WIN: begin
        op_a = {1'b0, hi};
        op_b = {1'b0, lo};
      end
      DU_LOAD: begin
        op_a = {1'b0, volt};
        op_b = {1'b0, lo};
      end
      DU_STEP: begin
        op_a = {rem, 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign flags.borrow = diff[13];
  assign flags.zero = (diff[12:0] == 13'd0);

  // quotient after this step
  always_comb begin
    quo_next = quo;
    if (du_op == DU_FIRST) begin
      quo_next = flags.zero ? FRAME_TICKS : 5'd0;
    end else if (du_op == DU_STEP) begin
      quo_next = {quo[3:0], ~flags.borrow};
    end
  end

  always_ff @(posedge clk) begin
    unique case (du_op)
      DU_WIN: begin
        den <= diff[11:0];
      end
      DU_LOAD: begin
        rem <= diff[11:0];
      end
      DU_FIRST: begin
        quo <= quo_next;
        if (flags.zero) begin
          rem <= 12'd0;
        end
      end
      DU_STEP: begin
        quo <= quo_next;
        rem <= flags.borrow ? op_a[11:0] : diff[11:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/cbds_cell_bank.sv
// Per-cell voltage and discharge count storage.
module cbds_cell_bank #(
  parameter int CELLS = 12,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cbds_pkg::bank_ctl_t  ctl,
  input  logic [IDX_W-1:0]     volt_idx,
  input  logic [11:0]          volt_data,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [11:0]          rd_volt,
  input  logic [IDX_W-1:0]     cnt_idx,
  input  logic [4:0]           cnt_data,
  output logic [CELLS-1:0]     mask
);
  import cbds_pkg::*;

  logic [11:0] volts  [CELLS];
  logic [4:0]  counts [CELLS];

  assign rd_volt = volts[rd_idx];

  // a cell discharges while its count is nonzero
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      mask[i] = (counts[i] != 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        volts[i]  <= 12'd0;
        counts[i] <= 5'd0;
      end
    end else begin
      if (ctl.volt_we) begin
        volts[volt_idx] <= volt_data;
      end
      if (ctl.clear_all) begin
        for (int i = 0; i < CELLS; i++) begin
          counts[i] <= 5'd0;
        end
      end else if (ctl.tick) begin
        for (int i = 0; i < CELLS; i++) begin
          if (counts[i] != 5'd0) begin
            counts[i] <= counts[i] - 5'd1;
          end
        end
      end else if (ctl.cnt_we) begin
        counts[cnt_idx] <= cnt_data;
      end
    end
  end

endmodule

// File: verif/cell_balance_discharge_scheduler_tb.sv
`timescale 1ns / 1ps

module cell_balance_discharge_scheduler_tb;
  import cbds_pkg::*;

  localparam int NCELLS = 12;

  // codes the package does not name
  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [1:0] PS_NORMAL       = 2'd0;
  localparam logic [1:0] PS_SPARE        = 2'd3;
  localparam logic [2:0] REG_FAULT_LIMIT = 3'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  mode;
    logic [3:0]  cell_req;
    logic [11:0] voltage;
    logic [11:0] win_low;
    logic [11:0] win_high;
    logic [1:0]  poll_status;
  } req_t;

  typedef struct packed {
    logic [11:0] load_mask;
    logic        load_update;
    logic        led_on;
    logic [1:0]  limit_event;
    logic        cable_break;
    logic        standby_request;
  } sched_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = '0;
  logic [1:0]  mode = '0;
  logic [3:0]  cell_req = '0;
  logic [11:0] voltage = '0;
  logic [11:0] win_low = '0;
  logic [11:0] win_high = '0;
  logic [1:0]  poll_status = '0;
  logic        done;
  logic [11:0] load_mask;
  logic        load_update;
  logic        led_on;
  logic [1:0]  limit_event;
  logic        cable_break;
  logic        standby_request;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cell_balance_discharge_scheduler #(.CELLS(NCELLS)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .mode(mode),
    .cell_req(cell_req),
    .voltage(voltage),
    .win_low(win_low),
    .win_high(win_high),
    .poll_status(poll_status),
    .done(done),
    .load_mask(load_mask),
    .load_update(load_update),
    .led_on(led_on),
    .limit_event(limit_event),
    .cable_break(cable_break),
    .standby_request(standby_request),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scheduler mirror, reset values
  mode_t       bal_mode = MODE_SURV;
  logic [4:0]  bal_frame = '0;
  logic [11:0] cell_mv [NCELLS];
  logic [4:0]  dis_count [NCELLS];
  logic [7:0]  disc_polls = '0;
  logic        led_level = 1'b0;
  logic [7:0]  fault_limit_val = FAULT_LIMIT_RST;

  sched_out_t  pending_outputs [$];
  int          mismatch_count = 0;
  int          quiet_left = 0;

  initial begin
    for (int i = 0; i < NCELLS; i++) begin
      cell_mv[i] = '0;
      dis_count[i] = '0;
    end
  end

  // poll status handling shared by active and surveillance ticks
  function automatic void eval_poll(logic [1:0] ps, inout sched_out_t o);
    if (ps == PS_LIMIT) begin
      o.limit_event = LE_LIMIT;
    end else if (ps == PS_DISC) begin
      if (disc_polls != 8'hFF) disc_polls++;
      if (disc_polls > fault_limit_val) o.cable_break = 1'b1;
    end else begin
      disc_polls = '0;
      o.limit_event = LE_OK;
    end
  endfunction

  // expected output of one request; advances the mirror state
  function automatic sched_out_t balance_step(req_t r);
    sched_out_t o;
    int lo, hi, v;
    o = '0;
    case (r.op)
      OP_MODE: bal_mode = mode_t'(r.mode);
      OP_VOLT: if (r.cell_req < NCELLS) cell_mv[r.cell_req] = r.voltage;
      OP_TICK: begin
        case (bal_mode)
          MODE_ACTIVE: begin
            // new frame: reschedule discharge counts from the window
            if (bal_frame == 0) begin
              bal_frame = FRAME_TICKS;
              lo = r.win_low;
              hi = r.win_high;
              for (int i = 0; i < NCELLS; i++) begin
                v = cell_mv[i];
                if (hi == lo)
                  dis_count[i] = '0;
                else if (hi > lo && v >= lo && v <= hi)
                  dis_count[i] = 5'((int'(FRAME_TICKS) * (v - lo)) / (hi - lo));
              end
            end
            bal_frame--;
            for (int i = 0; i < NCELLS; i++) begin
              if (dis_count[i] != 0) begin
                dis_count[i]--;
                o.load_mask[i] = 1'b1;
              end
            end
            o.load_update = 1'b1;
            led_level = ~led_level;
            eval_poll(r.poll_status, o);
          end
          MODE_SURV: begin
            if (bal_frame != 0) begin
              bal_frame = '0;
              led_level = 1'b0;
              o.load_update = 1'b1;
            end
            eval_poll(r.poll_status, o);
          end
          MODE_STANDBY: begin
            o.standby_request = 1'b1;
            bal_mode = MODE_OFF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.led_on = led_level;
    return o;
  endfunction

  // request builders; unused fields carry noise
  function automatic req_t noise_req();
    req_t r;
    r.op = 2'($urandom);
    r.mode = 2'($urandom);
    r.cell_req = 4'($urandom);
    r.voltage = 12'($urandom);
    r.win_low = 12'($urandom);
    r.win_high = 12'($urandom);
    r.poll_status = 2'($urandom);
    return r;
  endfunction

  function automatic req_t mode_req(mode_t m);
    req_t r;
    r = noise_req();
    r.op = OP_MODE;
    r.mode = m;
    return r;
  endfunction

  function automatic req_t volt_req(logic [3:0] cell_idx, logic [11:0] mv);
    req_t r;
    r = noise_req();
    r.op = OP_VOLT;
    r.cell_req = cell_idx;
    r.voltage = mv;
    return r;
  endfunction

  function automatic req_t tick_req(logic [11:0] lo, logic [11:0] hi, logic [1:0] ps);
    req_t r;
    r = noise_req();
    r.op = OP_TICK;
    r.win_low = lo;
    r.win_high = hi;
    r.poll_status = ps;
    return r;
  endfunction

  // mostly ticks with windows around the stored voltages; flood mode is
  // mostly disconnected polls to drive the counter into saturation
  function automatic req_t rand_req(bit flood);
    int unsigned sel, w, ps_sel;
    int vmin, vmax, a, lo, hi;
    logic [1:0] ps;
    mode_t m;
    logic [11:0] mv;
    sel = $urandom_range(0, 99);
    ps_sel = $urandom_range(0, 99);
    if (flood)
      ps = (ps_sel < 90) ? PS_DISC : (ps_sel < 94) ? PS_NORMAL :
           (ps_sel < 98) ? PS_LIMIT : PS_SPARE;
    else
      ps = (ps_sel < 70) ? PS_NORMAL : (ps_sel < 80) ? PS_LIMIT :
           (ps_sel < 95) ? PS_DISC : PS_SPARE;
    if (sel < (flood ? 92 : 65)) begin
      vmin = 4095;
      vmax = 0;
      for (int i = 0; i < NCELLS; i++) begin
        if (cell_mv[i] < vmin) vmin = cell_mv[i];
        if (cell_mv[i] > vmax) vmax = cell_mv[i];
      end
      w = $urandom_range(0, 99);
      if (w < 55) begin
        lo = vmin - int'($urandom_range(0, 60));
        hi = vmax + int'($urandom_range(0, 60));
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
      end else if (w < 70) begin
        // narrowed window: some cells fall outside
        lo = vmin + int'($urandom_range(0, (vmax - vmin) / 2));
        hi = vmax - int'($urandom_range(0, (vmax - vmin) / 2));
      end else if (w < 80) begin
        lo = $urandom_range(0, 4095);
        hi = lo;
      end else if (w < 90) begin
        a = $urandom_range(1, 4095);
        lo = a;
        hi = $urandom_range(0, a - 1);
      end else begin
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
      end
      return tick_req(12'(lo), 12'(hi), ps);
    end
    if (sel < (flood ? 97 : 91)) begin
      w = $urandom_range(0, 99);
      if (w < 60) mv = 12'(2800 + $urandom_range(0, 400));
      else if (w < 90) mv = 12'($urandom);
      else mv = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      return volt_req(($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, NCELLS - 1)) :
                      4'($urandom_range(NCELLS, 15)), mv);
    end
    if (sel < (flood ? 100 : 97)) begin
      w = $urandom_range(0, 99);
      if (flood) m = (w < 70) ? MODE_SURV : MODE_ACTIVE;
      else m = (w < 60) ? MODE_ACTIVE : (w < 85) ? MODE_SURV :
               (w < 95) ? MODE_STANDBY : MODE_OFF;
      return mode_req(m);
    end
    return tick_req(12'($urandom), 12'($urandom), ps) | {OP_UNUSED, 44'h0};
  endfunction

  // idle cycles before the next request: mostly short, some long, some bursts
  function automatic int pick_gap();
    int unsigned s;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    s = $urandom_range(0, 99);
    if (s < 4) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (s < 40) return 0;
    if (s < 85) return $urandom_range(1, 3);
    if (s < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // issue one request and log its expected output once it is taken
  task automatic send_req(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= r.op;
    mode <= r.mode;
    cell_req <= r.cell_req;
    voltage <= r.voltage;
    win_low <= r.win_low;
    win_high <= r.win_high;
    poll_status <= r.poll_status;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_outputs.push_back(balance_step(r));
  endtask

  // wait until every request has reported back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic read_fault_limit();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_FAULT_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("fault_limit readback", {24'h0, fault_limit_val}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write, only while the scheduler is idle; upper bits are noise
  task automatic set_fault_limit(logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_FAULT_LIMIT;
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fault_limit_val = val;
    read_fault_limit();
  endtask

  // output checker: the receiver never stalls
  always @(posedge clk) begin : result_check
    sched_out_t want;
    if (!rst && done) begin
      if (pending_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result strobe with no request outstanding", $time);
      end else begin
        want = pending_outputs.pop_front();
        check_field("load_mask", 32'(want.load_mask), 32'(load_mask));
        check_field("load_update", 32'(want.load_update), 32'(load_update));
        check_field("led_on", 32'(want.led_on), 32'(led_on));
        check_field("limit_event", 32'(want.limit_event), 32'(limit_event));
        check_field("cable_break", 32'(want.cable_break), 32'(cable_break));
        check_field("standby_request", 32'(want.standby_request),
                    32'(standby_request));
      end
    end
  end

  // a surveillance tick, voltage writes, ignored writes and the unused opcode
  task automatic test_idle_requests();
    send_req(tick_req(12'h000, 12'hFFF, PS_NORMAL));
    send_req(noise_req() | {OP_UNUSED, 44'h0});
    send_req(volt_req(4'd15, 12'hFFF));
    send_req(volt_req(4'(NCELLS), 12'hABC));
    send_req(volt_req(4'd0, 12'h000));
    send_req(volt_req(4'(NCELLS - 1), 12'hFFF));
    send_req(volt_req(4'd5, 12'h800));
    send_req(volt_req(4'd1, 12'd1000));
    drain();
  endtask

  // frame start scheduling, inverted and zero-width windows, poll codes
  task automatic test_frame_schedule();
    send_req(mode_req(MODE_ACTIVE));
    send_req(tick_req(12'h000, 12'hFFF, PS_NORMAL));
    send_req(mode_req(MODE_SURV));
    send_req(tick_req(12'h000, 12'hFFF, PS_LIMIT));
    send_req(tick_req(12'h000, 12'hFFF, PS_SPARE));
    send_req(mode_req(MODE_ACTIVE));
    send_req(tick_req(12'd4000, 12'd10, PS_DISC));
    send_req(mode_req(MODE_SURV));
    send_req(tick_req(12'h000, 12'hFFF, PS_NORMAL));
    send_req(mode_req(MODE_ACTIVE));
    send_req(tick_req(12'd500, 12'd500, PS_NORMAL));
    drain();
  endtask

  // a tick in standby asks the monitor to sleep and turns it off, then ticks do nothing
  task automatic test_standby();
    send_req(mode_req(MODE_STANDBY));
    send_req(tick_req(12'h000, 12'hFFF, PS_DISC));
    send_req(tick_req(12'h000, 12'hFFF, PS_LIMIT));
    send_req(mode_req(MODE_SURV));
    drain();
  endtask

  // random traffic; ignored requests do not count toward n
  task automatic test_random_traffic(int n, bit flood);
    req_t r;
    int taken;
    taken = 0;
    while (taken < n) begin
      r = rand_req(flood);
      send_req(r);
      if (r.op != OP_UNUSED && !(r.op == OP_VOLT && r.cell_req >= NCELLS)) taken++;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_fault_limit();
    test_idle_requests();
    test_frame_schedule();
    test_standby();
    set_fault_limit(8'd0);
    test_random_traffic(250, 1'b0);
    set_fault_limit(8'd255);
    test_random_traffic(250, 1'b0);
    set_fault_limit(8'd254);
    test_random_traffic(300, 1'b1);
    set_fault_limit(8'($urandom_range(1, 253)));
    test_random_traffic(250, 1'b0);
    set_fault_limit(8'd2);
    test_random_traffic(200, 1'b1);
    drain();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hang guard
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
